@@ hdl/cosserat_bend_twist_projection_unit_defines.svh @@
// Assertion macros used by the checker of the bend-twist projection unit.
`ifndef COSSERAT_BEND_TWIST_PROJECTION_UNIT_DEFINES_SVH
`define COSSERAT_BEND_TWIST_PROJECTION_UNIT_DEFINES_SVH

// Same-cycle implication, clocked on aclk, off during reset.
`define CBT_ASSERT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, clocked on aclk, off during reset.
`define CBT_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ hdl/cbt_pkg.sv @@
// Constants and register codes of the bend-twist projection unit.
`default_nettype none

package cbt_pkg;

    localparam int WORD_BITS    = 32;
    localparam int FRAC_BITS    = 29;
    localparam int NEWTON_STEPS = 6;

    localparam int FIELD_BITS = 32;
    localparam int VIOL_BITS  = 31;
    localparam int IN_BITS    = 12 * FIELD_BITS;
    localparam int OUT_BITS   = 8 * FIELD_BITS + VIOL_BITS + 1;

    localparam int SHARE_BITS = 30;
    localparam int IDX_BITS   = 1;
    localparam logic [SHARE_BITS-1:0] SHARE_RESET = 30'd268435456;

    typedef enum logic [IDX_BITS-1:0] {
        REG_SHARE_FIRST  = 1'b0,
        REG_SHARE_SECOND = 1'b1
    } cbt_reg_t;

endpackage

`default_nettype wire

@@ hdl/cosserat_bend_twist_projection_unit.sv @@
// Bend-twist projection pipeline for one Cosserat rod constraint per item.
`default_nettype none

// Takes one constraint item per cycle and returns one result item per constraint,
// in order. There are 20 + 4*NEWTON_STEPS register stages. 15 stages form the Darboux
// error and the two corrections. Three parallel normalization lanes then each run
// 3 set-up stages, 4 stages per Newton inverse square root step (y*y, s*y*y, 3-t,
// halved product) and one scaling stage. A final output register follows. The whole
// pipeline advances on one enable. While a result item waits with m_tready low,
// every stage holds and s_tready is low. Otherwise an item enters every cycle. A
// configuration write sets a share register, from which the step factors are
// registered. Writes are meant for an idle block.
module cosserat_bend_twist_projection_unit #(
    parameter int WORD_BITS    = cbt_pkg::WORD_BITS,
    parameter int FRAC_BITS    = cbt_pkg::FRAC_BITS,
    parameter int NEWTON_STEPS = cbt_pkg::NEWTON_STEPS
) (
    input  wire logic                            aclk,
    input  wire logic                            aresetn,
    // first_w, first_x, first_y, first_z, second_w, second_x, second_y,
    // second_z, rest_w, rest_x, rest_y, rest_z (32 bits each)
    input  wire logic [cbt_pkg::IN_BITS-1:0]     s_tdata,
    input  wire logic                            s_tvalid,
    output logic                                 s_tready,
    // new_first_w/x/y/z, new_second_w/x/y/z (32 bits each), violation (31), pad
    output logic [cbt_pkg::OUT_BITS-1:0]         m_tdata,
    output logic                                 m_tvalid,
    input  wire logic                            m_tready,
    input  wire logic                            cfg_wr_en,
    input  wire logic [cbt_pkg::IDX_BITS-1:0]    cfg_index,
    input  wire logic [cbt_pkg::SHARE_BITS-1:0]  cfg_wdata
);

    typedef logic signed [WORD_BITS-1:0] word_t;
    typedef struct packed { word_t w; word_t x; word_t y; word_t z; } quat_t;
    typedef logic [15:0][WORD_BITS-1:0] prod_t;

    localparam int PW = 2 * WORD_BITS + 1;
    localparam int K  = NEWTON_STEPS;
    localparam int LF = 3 + 4 * K;
    localparam int VL = 17 + LF;
    localparam int FB = cbt_pkg::FIELD_BITS;

    localparam word_t WMAX = $signed({1'b0, {(WORD_BITS-1){1'b1}}});
    localparam word_t WMIN = $signed({1'b1, {(WORD_BITS-1){1'b0}}});
    localparam logic signed [64:0] WMAX_X = 65'(WMAX);
    localparam logic signed [64:0] WMIN_X = 65'(WMIN);
    localparam logic [PW-1:0] HALF = PW'(1) << (FRAC_BITS - 1);
    localparam word_t CENT = word_t'(((65'd1 << FRAC_BITS) + 65'd50) / 65'd100);
    localparam logic [WORD_BITS+1:0] THREE_X = (WORD_BITS+2)'(3) << FRAC_BITS;
    localparam word_t THREE = (THREE_X > (WORD_BITS+2)'(WMAX)) ? WMAX : word_t'(THREE_X);

    function automatic word_t mulq(word_t a, word_t b);
        logic neg;
        logic [WORD_BITS-1:0] ma, mb;
        logic [PW-1:0] r;
        neg = a[WORD_BITS-1] ^ b[WORD_BITS-1];
        ma  = a[WORD_BITS-1] ? WORD_BITS'(-a) : WORD_BITS'(a);
        mb  = b[WORD_BITS-1] ? WORD_BITS'(-b) : WORD_BITS'(b);
        r   = ((PW'(ma) * PW'(mb)) + HALF) >> FRAC_BITS;
        if (neg) begin
            if (r >= (PW'(1) << (WORD_BITS - 1))) mulq = WMIN;
            else mulq = word_t'(-r);
        end else if (r > PW'(WMAX)) begin
            mulq = WMAX;
        end else begin
            mulq = word_t'(r);
        end
    endfunction

    function automatic word_t sat(logic signed [WORD_BITS:0] t);
        if (t > (WORD_BITS+1)'(WMAX)) sat = WMAX;
        else if (t < (WORD_BITS+1)'(WMIN)) sat = WMIN;
        else sat = word_t'(t);
    endfunction

    function automatic word_t sadd(word_t a, word_t b);
        sadd = sat((WORD_BITS+1)'(a) + (WORD_BITS+1)'(b));
    endfunction

    function automatic word_t ssub(word_t a, word_t b);
        ssub = sat((WORD_BITS+1)'(a) - (WORD_BITS+1)'(b));
    endfunction

    function automatic word_t sneg(word_t a);
        sneg = (a == WMIN) ? WMAX : -a;
    endfunction

    function automatic word_t half(word_t v);
        logic signed [WORD_BITS:0] t;
        t = (WORD_BITS+1)'(v) + $signed({{WORD_BITS{1'b0}}, v[WORD_BITS-1]});
        half = word_t'(t >>> 1);
    endfunction

    function automatic word_t clamp_in(logic signed [FB-1:0] v);
        logic signed [64:0] t;
        t = 65'(v);
        if (t > WMAX_X) clamp_in = WMAX;
        else if (t < WMIN_X) clamp_in = WMIN;
        else clamp_in = word_t'(t);
    endfunction

    function automatic word_t from_share(logic [cbt_pkg::SHARE_BITS-1:0] v);
        logic signed [64:0] t;
        t = $signed({{(65 - cbt_pkg::SHARE_BITS){1'b0}}, v});
        from_share = (t > WMAX_X) ? WMAX : word_t'(t);
    endfunction

    function automatic logic [FB-1:0] out_field(word_t v);
        logic signed [64:0] t;
        t = 65'(v);
        if (t > 65'sd2147483647) out_field = 32'h7fff_ffff;
        else if (t < -65'sd2147483648) out_field = 32'h8000_0000;
        else out_field = FB'(t);
    endfunction

    function automatic logic [cbt_pkg::VIOL_BITS-1:0] viol_field(word_t v);
        logic signed [64:0] t;
        t = 65'(v);
        if (t < 0) viol_field = '0;
        else if (t > 65'sd2147483647) viol_field = '1;
        else viol_field = cbt_pkg::VIOL_BITS'(t);
    endfunction

    function automatic quat_t conj(quat_t a);
        conj = '{w: a.w, x: sneg(a.x), y: sneg(a.y), z: sneg(a.z)};
    endfunction

    function automatic quat_t drop_scalar(quat_t a);
        drop_scalar = '{w: '0, x: a.x, y: a.y, z: a.z};
    endfunction

    function automatic prod_t qprod(quat_t a, quat_t b);
        prod_t p;
        p[0]  = mulq(a.w, b.w); p[1]  = mulq(a.x, b.x);
        p[2]  = mulq(a.y, b.y); p[3]  = mulq(a.z, b.z);
        p[4]  = mulq(a.w, b.x); p[5]  = mulq(a.x, b.w);
        p[6]  = mulq(a.y, b.z); p[7]  = mulq(a.z, b.y);
        p[8]  = mulq(a.w, b.y); p[9]  = mulq(a.x, b.z);
        p[10] = mulq(a.y, b.w); p[11] = mulq(a.z, b.x);
        p[12] = mulq(a.w, b.z); p[13] = mulq(a.x, b.y);
        p[14] = mulq(a.y, b.x); p[15] = mulq(a.z, b.w);
        qprod = p;
    endfunction

    function automatic quat_t qsum(prod_t p);
        quat_t r;
        r.w = ssub(ssub(ssub(p[0], p[1]), p[2]), p[3]);
        r.x = ssub(sadd(sadd(p[4], p[5]), p[6]), p[7]);
        r.y = sadd(sadd(ssub(p[8], p[9]), p[10]), p[11]);
        r.z = sadd(ssub(sadd(p[12], p[13]), p[14]), p[15]);
        qsum = r;
    endfunction

    function automatic quat_t squares(quat_t a);
        squares = '{w: mulq(a.w, a.w), x: mulq(a.x, a.x),
                    y: mulq(a.y, a.y), z: mulq(a.z, a.z)};
    endfunction

    function automatic word_t sum4(quat_t a);
        sum4 = sadd(sadd(sadd(a.w, a.x), a.y), a.z);
    endfunction

    function automatic quat_t scale(word_t k, quat_t a);
        scale = '{w: mulq(k, a.w), x: mulq(k, a.x), y: mulq(k, a.y), z: mulq(k, a.z)};
    endfunction

    // Newton start value from the position of the top set bit.
    function automatic word_t isqrt_seed(word_t s);
        int p, e, sh;
        p = 0;
        for (int i = 1; i < WORD_BITS; i++) begin
            if (s[i]) p = i;
        end
        e  = FRAC_BITS - p;
        sh = FRAC_BITS + (e >>> 1);
        if (sh >= WORD_BITS - 1) isqrt_seed = WMAX;
        else if (sh < 0) isqrt_seed = word_t'(1);
        else isqrt_seed = word_t'(1) <<< sh;
    endfunction

    logic en;
    logic [VL-1:0] vld_reg;
    logic [cbt_pkg::SHARE_BITS-1:0] share_first_reg, share_second_reg;
    word_t kq_reg, ku_reg;

    // main path
    quat_t q_reg [0:14];
    quat_t u_reg [0:14];
    quat_t r_reg [0:2];
    quat_t d_reg [6:14];
    quat_t dr_reg;
    quat_t dp_reg [3:5];
    quat_t dm_reg [3:5];
    quat_t sqp_reg, sqm_reg, cq_reg, mq_reg, cu_reg, mu_reg;
    word_t np_reg, nm_reg;
    prod_t pa_reg, pb_reg, pc_reg;

    // normalization lanes: first, second, error vector
    quat_t lane_in [3];
    quat_t vl_reg [3][0:LF-1];
    word_t sl_reg [3][1:LF-1];
    quat_t sq_reg [3];
    word_t y_reg  [3][0:K];
    word_t ya_reg [3][0:K-1];
    word_t yy_reg [3][0:K-1];
    word_t yb_reg [3][0:K-1];
    word_t t_reg  [3][0:K-1];
    word_t yc_reg [3][0:K-1];
    word_t c_reg  [3][0:K-1];
    quat_t f_reg  [3];
    logic [cbt_pkg::OUT_BITS-1:0] m_tdata_reg;

    assign en       = !vld_reg[VL-1] || m_tready;
    assign s_tready = en;
    assign m_tvalid = vld_reg[VL-1];
    assign m_tdata  = m_tdata_reg;

    assign lane_in[0] = q_reg[14];
    assign lane_in[1] = u_reg[14];
    assign lane_in[2] = d_reg[14];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            share_first_reg  <= cbt_pkg::SHARE_RESET;
            share_second_reg <= cbt_pkg::SHARE_RESET;
        end else if (cfg_wr_en) begin
            case (cbt_pkg::cbt_reg_t'(cfg_index))
                cbt_pkg::REG_SHARE_FIRST:  share_first_reg  <= cfg_wdata;
                cbt_pkg::REG_SHARE_SECOND: share_second_reg <= cfg_wdata;
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        kq_reg <= mulq(CENT, from_share(share_first_reg));
        ku_reg <= mulq(CENT, from_share(share_second_reg));
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (en) begin
            vld_reg <= {vld_reg[VL-2:0], s_tvalid};
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            // stages 10 and 14 take the corrected quaternions below
            for (int i = 1; i < 15; i++) begin
                if (i != 10) q_reg[i] <= q_reg[i-1];
                if (i != 14) u_reg[i] <= u_reg[i-1];
            end
            for (int i = 1; i < 3; i++) r_reg[i] <= r_reg[i-1];
            for (int i = 7; i < 15; i++) d_reg[i] <= d_reg[i-1];
            for (int i = 4; i < 6; i++) begin
                dp_reg[i] <= dp_reg[i-1];
                dm_reg[i] <= dm_reg[i-1];
            end

            q_reg[0] <= '{w: clamp_in(s_tdata[0*FB +: FB]), x: clamp_in(s_tdata[1*FB +: FB]),
                          y: clamp_in(s_tdata[2*FB +: FB]), z: clamp_in(s_tdata[3*FB +: FB])};
            u_reg[0] <= '{w: clamp_in(s_tdata[4*FB +: FB]), x: clamp_in(s_tdata[5*FB +: FB]),
                          y: clamp_in(s_tdata[6*FB +: FB]), z: clamp_in(s_tdata[7*FB +: FB])};
            r_reg[0] <= '{w: clamp_in(s_tdata[8*FB +: FB]), x: clamp_in(s_tdata[9*FB +: FB]),
                          y: clamp_in(s_tdata[10*FB +: FB]), z: clamp_in(s_tdata[11*FB +: FB])};

            pa_reg <= qprod(conj(q_reg[0]), u_reg[0]);
            dr_reg <= qsum(pa_reg);
            dp_reg[3] <= '{w: sadd(dr_reg.w, r_reg[2].w), x: sadd(dr_reg.x, r_reg[2].x),
                           y: sadd(dr_reg.y, r_reg[2].y), z: sadd(dr_reg.z, r_reg[2].z)};
            dm_reg[3] <= '{w: ssub(dr_reg.w, r_reg[2].w), x: ssub(dr_reg.x, r_reg[2].x),
                           y: ssub(dr_reg.y, r_reg[2].y), z: ssub(dr_reg.z, r_reg[2].z)};
            sqp_reg <= squares(dp_reg[3]);
            sqm_reg <= squares(dm_reg[3]);
            np_reg  <= sum4(sqp_reg);
            nm_reg  <= sum4(sqm_reg);
            // ties take the difference; scalar part of the error is dropped
            d_reg[6] <= drop_scalar((np_reg < nm_reg) ? dp_reg[5] : dm_reg[5]);

            pb_reg <= qprod(u_reg[6], d_reg[6]);
            cq_reg <= qsum(pb_reg);
            mq_reg <= scale(kq_reg, cq_reg);
            q_reg[10] <= '{w: sadd(q_reg[9].w, mq_reg.w), x: sadd(q_reg[9].x, mq_reg.x),
                           y: sadd(q_reg[9].y, mq_reg.y), z: sadd(q_reg[9].z, mq_reg.z)};

            // second correction uses the already corrected first quaternion
            pc_reg <= qprod(q_reg[10], d_reg[10]);
            cu_reg <= qsum(pc_reg);
            mu_reg <= scale(ku_reg, cu_reg);
            u_reg[14] <= '{w: ssub(u_reg[13].w, mu_reg.w), x: ssub(u_reg[13].x, mu_reg.x),
                           y: ssub(u_reg[13].y, mu_reg.y), z: ssub(u_reg[13].z, mu_reg.z)};
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            for (int l = 0; l < 3; l++) begin
                for (int j = 2; j < LF; j++) begin
                    vl_reg[l][j] <= vl_reg[l][j-1];
                    sl_reg[l][j] <= sl_reg[l][j-1];
                end
                vl_reg[l][0] <= lane_in[l];
                sq_reg[l]    <= squares(lane_in[l]);
                sl_reg[l][1] <= sum4(sq_reg[l]);
                // error lane carries its squared norm so the scaling stage yields |D|
                if (l == 2) vl_reg[l][1] <= '{w: sum4(sq_reg[l]), x: '0, y: '0, z: '0};
                else vl_reg[l][1] <= vl_reg[l][0];
                y_reg[l][0] <= isqrt_seed(sl_reg[l][1]);

                for (int i = 0; i < K; i++) begin
                    ya_reg[l][i]  <= y_reg[l][i];
                    yy_reg[l][i]  <= mulq(y_reg[l][i], y_reg[l][i]);
                    yb_reg[l][i]  <= ya_reg[l][i];
                    t_reg[l][i]   <= mulq(sl_reg[l][3+4*i], yy_reg[l][i]);
                    yc_reg[l][i]  <= yb_reg[l][i];
                    c_reg[l][i]   <= ssub(THREE, t_reg[l][i]);
                    y_reg[l][i+1] <= half(mulq(yc_reg[l][i], c_reg[l][i]));
                end

                // pass through when the norm is not positive
                if (sl_reg[l][LF-1] > 0) f_reg[l] <= scale(y_reg[l][K], vl_reg[l][LF-1]);
                else f_reg[l] <= vl_reg[l][LF-1];
            end

            m_tdata_reg <= {1'b0, viol_field(f_reg[2].w),
                            out_field(f_reg[1].z), out_field(f_reg[1].y),
                            out_field(f_reg[1].x), out_field(f_reg[1].w),
                            out_field(f_reg[0].z), out_field(f_reg[0].y),
                            out_field(f_reg[0].x), out_field(f_reg[0].w)};
        end
    end

endmodule

`default_nettype wire

@@ hdl/cbt_checker.sv @@
// Port-level checker of the bend-twist projection unit, bound to the top level.
`default_nettype none
`include "cosserat_bend_twist_projection_unit_defines.svh"

module cbt_checker (
    input wire logic                          aclk,
    input wire logic                          aresetn,
    input wire logic                          s_tvalid,
    input wire logic                          s_tready,
    input wire logic                          m_tvalid,
    input wire logic                          m_tready,
    input wire logic [cbt_pkg::OUT_BITS-1:0]  m_tdata
);

    logic [6:0] pending_reg, pending_next;

    // items taken in but not yet delivered
    always_comb begin
        pending_next = pending_reg + 7'(s_tvalid && s_tready) - 7'(m_tvalid && m_tready);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pending_reg <= '0;
        end else begin
            pending_reg <= pending_next;
        end
    end

    `CBT_ASSERT_NEXT(a_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata), "result item changed under stall")
    `CBT_ASSERT(a_no_invent, m_tvalid, pending_reg != 7'd0, "result item without an accepted item")
    `CBT_ASSERT(a_flow, !m_tvalid, s_tready, "input stalled while output is empty")
    `CBT_ASSERT(a_pad, m_tvalid, !m_tdata[cbt_pkg::OUT_BITS-1], "pad bit of result item set")

endmodule

bind cosserat_bend_twist_projection_unit cbt_checker u_cbt_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

`default_nettype wire
